@@ hw/rtl/bilinear_texture_sampler_assert.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the bilinear texture sampler
// Clocked on clk, disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH

// same-cycle implication
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bts_pkg.sv @@
// -----------------------------------------------------------------------------
// Bilinear texture sampler package
// Widths, codes and shared types.
// -----------------------------------------------------------------------------
package bts_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int SIDE_W      = 9;
	localparam int CHAN_W      = 16;
	localparam int TEXEL_W     = 4 * CHAN_W;
	localparam int IDX_W       = 16;
	localparam int STORE_DEPTH = 1 << IDX_W;
	localparam int WORD_W      = 32;
	localparam int COORD_W     = 16;
	localparam int OUT_W       = 18;
	localparam int FRAC_W      = 18;

	typedef enum logic {
		MODE_WRITE  = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

	typedef enum logic {
		FMT_RGBA8   = 1'b0,
		FMT_DEPTH16 = 1'b1
	} pix_fmt_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_FORMAT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]              base;
		logic signed [FRAC_W-1:0] frac;
	} axis_t;

	// side clamped to 2..MAX_SIDE
	function automatic logic [SIDE_W-1:0] eff_size(logic [SIDE_W-1:0] n);
		if (n < SIDE_W'(2))
			return SIDE_W'(2);
		else if (n > SIDE_W'(MAX_SIDE))
			return SIDE_W'(MAX_SIDE);
		else
			return n;
	endfunction

endpackage

@@ hw/rtl/bts_if.sv @@
// -----------------------------------------------------------------------------
// Bilinear texture sampler channels
// Request and result channels, valid/ready handshake.
// -----------------------------------------------------------------------------
interface bts_in_if import bts_pkg::*; ();
	logic               valid;
	logic               ready;
	mode_t              mode;
	logic [IDX_W-1:0]   texel_index;
	logic [WORD_W-1:0]  texel_word;
	logic [COORD_W-1:0] u_coord;
	logic [COORD_W-1:0] v_coord;

	modport source (output valid, mode, texel_index, texel_word, u_coord, v_coord,
		input ready);
	modport sink (input valid, mode, texel_index, texel_word, u_coord, v_coord,
		output ready);
endinterface

interface bts_out_if import bts_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] red_out;
	logic signed [OUT_W-1:0] green_out;
	logic signed [OUT_W-1:0] blue_out;
	logic signed [OUT_W-1:0] alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

@@ hw/rtl/bts_ram.sv @@
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module bts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/bilinear_texture_sampler.sv @@
// -----------------------------------------------------------------------------
// Bilinear texture sampler
// Texel store with a pipelined bilinear filter.
// -----------------------------------------------------------------------------
// Usage:
//  in_ch carries one transaction per item. mode MODE_WRITE converts texel_word
//  (RGBA8 bytes expanded to 16-bit unorm, or depth16 into red) and stores it at
//  texel_index. mode MODE_SAMPLE filters at (u_coord, v_coord), UQ0.16, and
//  returns one transaction on out_ch, signed Q2.16 per channel; writes return
//  nothing.
//  Throughput: one transaction per cycle unless out_ch stalls. Pipeline:
//  seven stages (s1..s7), which are coordinate scaling, floor and clamp,
//  the index multiply, the registered store read, the two lerp stages and
//  the rounding output register.
//  The store is held four times over, one copy per neighbour, so all four
//  texels come out of a single read; writes go to every copy. A write is
//  done in the same stage as sample reads, keeping program order.
//  Receiver stall: the whole pipe holds while out_ch.valid is high and
//  out_ch.ready low; in_ch.ready drops in that case only.
//  Reset: valid bits and registers clear (width 2, height 2, RGBA8). The
//  store is not cleared; sample only texels that were written.
//  Configure through the APB port only while idle.
// -----------------------------------------------------------------------------
module bilinear_texture_sampler import bts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bts_in_if.sink      in_ch,
	bts_out_if.source   out_ch
);

	// -------------------------------------------------------------- helpers
	function automatic axis_t axis_split(logic [COORD_W+SIDE_W-1:0] sc, logic [SIDE_W-1:0] n);
		logic signed [25:0] s;
		logic signed [25:0] d;
		logic [8:0]         fl;
		logic [8:0]         lim;
		logic [7:0]         f;
		axis_t              res;
		// shift down half a texel
		s   = $signed({1'b0, sc}) - 26'sd32768;
		fl  = s[24:16];
		lim = n - 9'd2;
		if (s < 0)
			f = '0;
		else if (fl > lim)
			f = lim[7:0];
		else
			f = fl[7:0];
		d        = s - $signed({2'b00, f, 16'h0000});
		res.base = f;
		res.frac = d[FRAC_W-1:0];
		return res;
	endfunction

	// unorm16 to Q.16, full scale reads as one
	function automatic logic [16:0] to_q16(logic [CHAN_W-1:0] c);
		return {1'b0, c} + {16'b0, c[CHAN_W-1]};
	endfunction

	// saturate Q.48 to [-0.5, 1.5], round half up to Q.16
	function automatic logic [OUT_W-1:0] finish(logic signed [55:0] r);
		logic signed [55:0] lo;
		logic signed [55:0] hi;
		logic signed [55:0] rc;
		lo = -(56'sd32768 <<< 32);
		hi = 56'sd98304 <<< 32;
		if (r < lo)
			rc = lo;
		else if (r > hi)
			rc = hi;
		else
			rc = r;
		rc = rc + (56'sd1 <<< 31);
		return rc[49:32];
	endfunction

	// ------------------------------------------------------------ config
	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	pix_fmt_t          format_q;
	logic [SIDE_W-1:0] eff_w;
	logic [SIDE_W-1:0] eff_h;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(2);
			height_q <= SIDE_W'(2);
			format_q <= FMT_RGBA8;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:  width_q  <= pwdata[SIDE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIDE_W-1:0];
				REG_FORMAT: format_q <= pix_fmt_t'(pwdata[0]);
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_WIDTH:  prdata = {23'b0, width_q};
			REG_HEIGHT: prdata = {23'b0, height_q};
			REG_FORMAT: prdata = {31'b0, format_q};
			default:    prdata = '0;
		endcase
	end

	assign eff_w = eff_size(width_q);
	assign eff_h = eff_size(height_q);

	// ------------------------------------------------------------ pipeline
	logic  en;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	mode_t mode_s1, mode_s2, mode_s3;

	// whole pipe moves unless a result waits
	assign en          = !v_s7 || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && (mode_s3 == MODE_SAMPLE);   // writes end at the store
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// s1: texel conversion, coordinate scaling
	logic [TEXEL_W-1:0]        texel_cv;
	logic [IDX_W-1:0]          idx_s1, idx_s2, idx_s3;
	logic [TEXEL_W-1:0]        texel_s1, texel_s2, texel_s3;
	logic [COORD_W+SIDE_W-1:0] sx_s1, sy_s1;

	always_comb begin
		if (format_q == FMT_RGBA8)
			texel_cv = {in_ch.texel_word[31:24], in_ch.texel_word[31:24],
				in_ch.texel_word[23:16], in_ch.texel_word[23:16],
				in_ch.texel_word[15:8], in_ch.texel_word[15:8],
				in_ch.texel_word[7:0], in_ch.texel_word[7:0]};
		else
			texel_cv = {48'b0, in_ch.texel_word[15:0]};
	end

	// s2: floor, clamp, fraction
	axis_t ax_s2, ay_s2;
	// s3: base index
	logic [IDX_W-1:0]         base_s3;
	logic [17:0]              base_full;
	logic signed [FRAC_W-1:0] dx_s3, dy_s3, dx_s4, dy_s4, dy_s5;

	assign base_full = ({10'b0, ay_s2.base} * {9'b0, eff_w}) + {10'b0, ax_s2.base};

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= in_ch.mode;
			idx_s1   <= in_ch.texel_index;
			texel_s1 <= texel_cv;
			sx_s1    <= {9'b0, in_ch.u_coord} * {16'b0, eff_w};
			sy_s1    <= {9'b0, in_ch.v_coord} * {16'b0, eff_h};

			mode_s2  <= mode_s1;
			idx_s2   <= idx_s1;
			texel_s2 <= texel_s1;
			ax_s2    <= axis_split(sx_s1, eff_w);
			ay_s2    <= axis_split(sy_s1, eff_h);

			mode_s3  <= mode_s2;
			idx_s3   <= idx_s2;
			texel_s3 <= texel_s2;
			base_s3  <= base_full[IDX_W-1:0];
			dx_s3    <= ax_s2.frac;
			dy_s3    <= ay_s2.frac;

			dx_s4    <= dx_s3;
			dy_s4    <= dy_s3;
			dy_s5    <= dy_s4;
		end
	end

	// store: four copies, bank k holds neighbour k (00, 10, 01, 11)
	logic                 st_we;
	logic                 st_re;
	logic [IDX_W-1:0]     raddr [4];
	logic [TEXEL_W-1:0]   rdata [4];

	assign st_we    = en && v_s3 && (mode_s3 == MODE_WRITE);
	assign st_re    = en && v_s3 && (mode_s3 == MODE_SAMPLE);
	assign raddr[0] = base_s3;
	assign raddr[1] = base_s3 + IDX_W'(1);
	assign raddr[2] = base_s3 + {7'b0, eff_w};
	assign raddr[3] = base_s3 + {7'b0, eff_w} + IDX_W'(1);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		bts_ram #(
			.WIDTH (TEXEL_W),
			.DEPTH (STORE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (st_we),
			.waddr (idx_s3),
			.wdata (texel_s3),
			.re    (st_re),
			.raddr (raddr[b]),
			.rdata (rdata[b])
		);
	end

	// s5: horizontal lerps, s6: vertical lerp, s7: output register
	logic signed [35:0]    c0_s5 [4];
	logic signed [35:0]    c1_s5 [4];
	logic signed [55:0]    r_s6  [4];
	logic [OUT_W-1:0]      res_s7 [4];
	logic signed [35:0]    c0_n [4];
	logic signed [35:0]    c1_n [4];
	logic signed [55:0]    r_n  [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [16:0]        a00, a10, a01, a11;
			logic signed [17:0] d0, d1;
			logic signed [36:0] dc;
			a00     = to_q16(rdata[0][k*CHAN_W +: CHAN_W]);
			a10     = to_q16(rdata[1][k*CHAN_W +: CHAN_W]);
			a01     = to_q16(rdata[2][k*CHAN_W +: CHAN_W]);
			a11     = to_q16(rdata[3][k*CHAN_W +: CHAN_W]);
			d0      = $signed({1'b0, a10}) - $signed({1'b0, a00});
			d1      = $signed({1'b0, a11}) - $signed({1'b0, a01});
			c0_n[k] = $signed({3'b0, a00, 16'h0000}) + (36'(d0) * 36'(dx_s4));
			c1_n[k] = $signed({3'b0, a01, 16'h0000}) + (36'(d1) * 36'(dx_s4));
			dc      = 37'(c1_s5[k]) - 37'(c0_s5[k]);
			r_n[k]  = ($signed(56'(c0_s5[k])) <<< 16) + (56'(dc) * 56'(dy_s5));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				c0_s5[k]  <= c0_n[k];
				c1_s5[k]  <= c1_n[k];
				r_s6[k]   <= r_n[k];
				res_s7[k] <= finish(r_s6[k]);
			end
		end
	end

	assign out_ch.valid     = v_s7;
	assign out_ch.red_out   = res_s7[0];
	assign out_ch.green_out = res_s7[1];
	assign out_ch.blue_out  = res_s7[2];
	assign out_ch.alpha_out = res_s7[3];

endmodule

@@ hw/rtl/bts_checker.sv @@
// -----------------------------------------------------------------------------
// Bilinear texture sampler checker
// Port-level assertions, bound to the top level.
// -----------------------------------------------------------------------------
`include "bilinear_texture_sampler_assert.svh"

module bts_checker import bts_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] red_out,
	input logic signed [OUT_W-1:0] green_out,
	input logic signed [OUT_W-1:0] blue_out,
	input logic signed [OUT_W-1:0] alpha_out
);

	logic in_range;

	assign in_range =
		(red_out >= -18'sd32768) && (red_out <= 18'sd98304) &&
		(green_out >= -18'sd32768) && (green_out <= 18'sd98304) &&
		(blue_out >= -18'sd32768) && (blue_out <= 18'sd98304) &&
		(alpha_out >= -18'sd32768) && (alpha_out <= 18'sd98304);

	`BTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`BTS_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(alpha_out), "result changed while stalled")
	`BTS_ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready, "request refused without a stalled result")
	`BTS_ASSERT_IMP(a_out_range, out_valid, in_range, "filtered value outside -0.5 .. 1.5")

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.red_out   (out_ch.red_out),
	.green_out (out_ch.green_out),
	.blue_out  (out_ch.blue_out),
	.alpha_out (out_ch.alpha_out)
);

@@ tb/bilinear_texture_sampler_checker.sv @@
// -----------------------------------------------------------------------------
// Bilinear texture sampler checker
// Watches the configuration port and both channels, keeps its own texel store
// and predicts each filtered sample, then compares results in order.
// -----------------------------------------------------------------------------
module bilinear_texture_sampler_checker import bts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	bts_in_if           in_ch,
	bts_out_if          out_ch,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [OUT_W-1:0] red;
		logic signed [OUT_W-1:0] green;
		logic signed [OUT_W-1:0] blue;
		logic signed [OUT_W-1:0] alpha;
	} colour_t;

	logic [TEXEL_W-1:0] texels [STORE_DEPTH];
	colour_t            colour_q[$];
	logic [SIDE_W-1:0]  width_reg, height_reg;
	pix_fmt_t           fmt_reg;

	assign pending = colour_q.size();

	function automatic int side_of(logic [SIDE_W-1:0] n);
		if (n < 2)
			return 2;
		if (n > MAX_SIDE)
			return MAX_SIDE;
		return int'(n);
	endfunction

	// stored unorm channel to Q.16, halves up
	function automatic longint unorm_q16(logic [CHAN_W-1:0] c);
		return ((longint'(c) << 16) + 32767) / 65535;
	endfunction

	function automatic void split_axis(logic [COORD_W-1:0] t, int n,
			output longint base, output longint frac);
		longint s;
		longint f;
		s = longint'(t) * n - 32768;
		f = (s < 0) ? -1 : (s >>> 16);
		if (f < 0)
			f = 0;
		if (f > n - 2)
			f = n - 2;
		base = f;
		frac = s - f * 65536;
	endfunction

	// Q.48 value saturated to -0.5..1.5 and rounded to Q.16
	function automatic logic signed [OUT_W-1:0] round_q48(longint r);
		longint lo;
		longint hi;
		longint v;
		lo = -32768 * 64'sd4294967296;
		hi = 98304 * 64'sd4294967296;
		if (r < lo)
			r = lo;
		if (r > hi)
			r = hi;
		v = ((r - lo + 64'sd2147483648) >>> 32) - 32768;
		return v[OUT_W-1:0];
	endfunction

	function automatic logic [TEXEL_W-1:0] pack_texel(logic [WORD_W-1:0] w, pix_fmt_t f);
		logic [TEXEL_W-1:0] t;
		longint b;
		t = '0;
		if (f == FMT_RGBA8) begin
			for (int k = 0; k < 4; k++) begin
				b = longint'(w[8*k +: 8]);
				t[CHAN_W*k +: CHAN_W] = CHAN_W'((b * 65535 + 127) / 255);
			end
		end else begin
			b = longint'(w[15:0]);
			t[CHAN_W-1:0] = CHAN_W'((b * 65535 + 32767) / 65535);
		end
		return t;
	endfunction

	function automatic colour_t filter_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
		colour_t res;
		longint x0, y0, dx, dy, a00, a10, a01, a11, c0, c1;
		int w, h;
		logic [IDX_W-1:0] i00, i10, i01, i11;
		logic signed [OUT_W-1:0] ch [4];
		w = side_of(width_reg);
		h = side_of(height_reg);
		split_axis(u, w, x0, dx);
		split_axis(v, h, y0, dy);
		i00 = IDX_W'(y0 * w + x0);
		i10 = IDX_W'(y0 * w + x0 + 1);
		i01 = IDX_W'((y0 + 1) * w + x0);
		i11 = IDX_W'((y0 + 1) * w + x0 + 1);
		for (int k = 0; k < 4; k++) begin
			a00 = unorm_q16(texels[i00][CHAN_W*k +: CHAN_W]);
			a10 = unorm_q16(texels[i10][CHAN_W*k +: CHAN_W]);
			a01 = unorm_q16(texels[i01][CHAN_W*k +: CHAN_W]);
			a11 = unorm_q16(texels[i11][CHAN_W*k +: CHAN_W]);
			c0 = a00 * 65536 + (a10 - a00) * dx;
			c1 = a01 * 65536 + (a11 - a01) * dx;
			ch[k] = round_q48(c0 * 65536 + (c1 - c0) * dy);
		end
		res.red = ch[0];
		res.green = ch[1];
		res.blue = ch[2];
		res.alpha = ch[3];
		return res;
	endfunction

	task automatic compare_field(string name, logic signed [OUT_W-1:0] exp_v,
			logic signed [OUT_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		colour_t exp_c;
		if (!arst_n) begin
			colour_q.delete();
			width_reg <= SIDE_W'(2);
			height_reg <= SIDE_W'(2);
			fmt_reg <= FMT_RGBA8;
			fail_count = 0;
			checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_WIDTH:  width_reg <= pwdata[SIDE_W-1:0];
					REG_HEIGHT: height_reg <= pwdata[SIDE_W-1:0];
					REG_FORMAT: fmt_reg <= pix_fmt_t'(pwdata[0]);
					default: ;
				endcase
			end
			// result side first: a sample accepted this edge cannot leave yet
			if (out_ch.valid && out_ch.ready) begin
				checked++;
				if (colour_q.size() == 0) begin
					$error("result transaction with no sample outstanding");
					fail_count++;
				end else begin
					exp_c = colour_q.pop_front();
					compare_field("red_out", exp_c.red, out_ch.red_out);
					compare_field("green_out", exp_c.green, out_ch.green_out);
					compare_field("blue_out", exp_c.blue, out_ch.blue_out);
					compare_field("alpha_out", exp_c.alpha, out_ch.alpha_out);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.mode == MODE_WRITE)
					texels[in_ch.texel_index] = pack_texel(in_ch.texel_word, fmt_reg);
				else
					colour_q.push_back(filter_at(in_ch.u_coord, in_ch.v_coord));
			end
		end
	end

endmodule

@@ tb/bilinear_texture_sampler_tb.sv @@
// -----------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Drives texel writes and bilinear samples under random idling and stalls,
// across several image sizes and both pixel formats; the checker predicts.
// -----------------------------------------------------------------------------
module bilinear_texture_sampler_tb import bts_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count, pending, checked;

	bts_in_if  in_ch ();
	bts_out_if out_ch ();

	bilinear_texture_sampler i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	bilinear_texture_sampler_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// stimulus-side view of the store: which indexes hold a texel
	bit wrote [STORE_DEPTH];
	int side_w, side_h;
	int n_writes, n_samples, n_settings, burst_left;
	int stall_pct;

	always #5 clk = ~clk;

	// receiver: random stalls, with a density that steps from none to heavy
	always @(posedge clk) begin
		int cyc;
		cyc++;
		if (cyc % 256 == 0)
			stall_pct = (cyc / 256) % 4 == 0 ? 0 : $urandom_range(10, 80);
		out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		#5ms;
		$display("bilinear_texture_sampler: mismatch");
		$finish;
	end

	function automatic int clamp_side(int n);
		return n < 2 ? 2 : (n > MAX_SIDE ? MAX_SIDE : n);
	endfunction

	// floor of the sample position on one axis, clamped to the image
	function automatic int axis_base(logic [COORD_W-1:0] t, int n);
		int s;
		int f;
		s = int'(t) * n - 32768;
		f = (s < 0) ? 0 : (s >>> 16);
		return f > n - 2 ? n - 2 : f;
	endfunction

	// one transaction on in_ch; returns at the edge where it was taken, or after the random gap that may end a burst
	task automatic send_item(mode_t m, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] word,
			logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
		bit got;
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.texel_index <= idx;
		in_ch.texel_word <= word;
		in_ch.u_coord <= u;
		in_ch.v_coord <= v;
		do begin
			@(negedge clk);
			got = in_ch.ready;
			@(posedge clk);
		end while (!got);
		if (m == MODE_WRITE) begin
			wrote[idx] = 1'b1;
			n_writes++;
		end else
			n_samples++;
		// bursts with random gaps between them
		if (--burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic write_texel(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] word);
		send_item(MODE_WRITE, idx, word, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	// fill any unwritten neighbour first, then take the sample
	task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
		int x0, y0;
		logic [IDX_W-1:0] nb [4];
		x0 = axis_base(u, side_w);
		y0 = axis_base(v, side_h);
		nb[0] = IDX_W'(y0 * side_w + x0);
		nb[1] = IDX_W'(y0 * side_w + x0 + 1);
		nb[2] = IDX_W'((y0 + 1) * side_w + x0);
		nb[3] = IDX_W'((y0 + 1) * side_w + x0 + 1);
		foreach (nb[k])
			if (!wrote[nb[k]])
				write_texel(nb[k], $urandom);
		send_item(MODE_SAMPLE, IDX_W'($urandom), $urandom, u, v);
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t r, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {r, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// only while idle: results drained, then past the pipe depth for trailing writes
	task automatic set_image(int w_raw, int h_raw, pix_fmt_t f);
		in_ch.valid <= 1'b0;
		drain();
		repeat (12) @(posedge clk);
		reg_write(REG_WIDTH, w_raw);
		reg_write(REG_HEIGHT, h_raw);
		reg_write(REG_FORMAT, 32'(f));
		side_w = clamp_side(w_raw);
		side_h = clamp_side(h_raw);
		n_settings++;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return COORD_W'(32768);
			3: return COORD_W'($urandom_range(0, 511));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic random_items(int count);
		int start;
		start = n_writes + n_samples;
		while (n_writes + n_samples - start < count) begin
			case ($urandom_range(0, 9))
				0, 1: write_texel(IDX_W'($urandom), $urandom);
				// refresh a texel inside the image
				2: write_texel(IDX_W'($urandom_range(0, side_w * side_h - 1)), $urandom);
				default: sample_at(pick_coord(), pick_coord());
			endcase
		end
	endtask

	initial begin
		int bigs;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_WRITE;
		in_ch.texel_index = '0;
		in_ch.texel_word = '0;
		in_ch.u_coord = '0;
		in_ch.v_coord = '0;
		out_ch.ready = 1'b1;
		stall_pct = 0;
		burst_left = 8;
		side_w = 2;
		side_h = 2;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset size 2x2, RGBA8, extreme texels and coordinates
		write_texel(16'd0, 32'h0000_0000);
		write_texel(16'd1, 32'hFFFF_FFFF);
		write_texel(16'd2, 32'h80FF_007F);
		write_texel(16'd3, 32'h01FE_5AA5);
		sample_at(16'd0, 16'd0);
		sample_at(16'hFFFF, 16'hFFFF);
		sample_at(16'd0, 16'hFFFF);
		sample_at(16'hFFFF, 16'd0);
		sample_at(16'd32768, 16'd32768);
		sample_at(16'd16384, 16'd49152);
		write_texel(16'hFFFF, 32'hFFFF_FFFF);
		// sizes below the floor act as 2; depth keeps only red
		set_image(0, 1, FMT_DEPTH16);
		write_texel(16'd1, 32'hABCD_FFFF);
		write_texel(16'd2, 32'h1234_0000);
		sample_at(16'd0, 16'hFFFF);
		sample_at(16'hFFFF, 16'd1);
		sample_at(16'd40000, 16'd20000);
		// format change leaves earlier texels as converted
		set_image(2, 2, FMT_RGBA8);
		sample_at(16'd32768, 16'd0);
		// widths above the ceiling act as 256
		set_image(511, 511, FMT_RGBA8);
		sample_at(16'hFFFF, 16'hFFFF);
		sample_at(16'd0, 16'd0);

		random_items(150);
		set_image(256, 256, FMT_DEPTH16);
		random_items(150);
		set_image(3, 5, FMT_DEPTH16);
		random_items(200);
		// hold off until every sample so far has come back
		in_ch.valid <= 1'b0;
		drain();
		set_image(17, 9, FMT_RGBA8);
		random_items(200);
		set_image(255, 2, FMT_RGBA8);
		random_items(150);
		set_image(2, 256, FMT_DEPTH16);
		random_items(150);
		for (bigs = 0; bigs < 4; bigs++) begin
			set_image($urandom_range(2, 40), $urandom_range(2, 40), pix_fmt_t'($urandom_range(0, 1)));
			random_items(150);
		end

		in_ch.valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d texel writes and %0d samples (%0d results checked)",
			n_writes, n_samples, checked);
		$display("over %0d image size and format settings, both pixel formats", n_settings);
		if (fail_count == 0)
			$display("bilinear_texture_sampler: match");
		else
			$display("bilinear_texture_sampler: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bts_pkg.sv
hw/rtl/bts_if.sv
hw/rtl/bts_ram.sv
hw/rtl/bilinear_texture_sampler.sv
hw/rtl/bts_checker.sv
tb/bilinear_texture_sampler_checker.sv
tb/bilinear_texture_sampler_tb.sv
